>>> src/rmi_pkg.sv
// ----------------------------------------------------------------------------
// Running median package
// Shared constants and the command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package rmi_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 16;
	localparam int COUNT_OUT_W    = 5;

	typedef struct packed {
		logic load;
		logic insert;
		logic select;
		logic finish;
	} rmi_cmd_t;

endpackage

>>> src/rmi_ctrl.sv
// ----------------------------------------------------------------------------
// Running median controller
// Sequences capture, insertion, middle selection and result loading for each
// item, and holds the output valid flag.
// ----------------------------------------------------------------------------
module rmi_ctrl
	import rmi_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output rmi_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_SELECT = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = ST_SELECT;
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = ST_FINISH;
			end
			ST_FINISH: begin
				// The result register may be reloaded once the old item leaves.
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.insert, cmd.select, cmd.finish}))
		else $error("controller issued more than one command");

	a_insert_then_select: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> cmd.select)
		else $error("selection did not follow insertion");

	a_finish_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) && out_valid_q && !m_tready |=> (state_q == ST_FINISH))
		else $error("result loaded over an item not yet taken");

endmodule

>>> src/rmi_datapath.sv
// ----------------------------------------------------------------------------
// Running median datapath
// Row of sorted cells with parallel compare-and-shift insertion, middle
// element selection and the registered result.
// ----------------------------------------------------------------------------
module rmi_datapath
	import rmi_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmi_cmd_t               cmd,
	input  logic [DATA_WIDTH-1:0]  sample,
	input  logic                   start_new,
	output logic [DATA_WIDTH:0]    median_x2,
	output logic [COUNT_OUT_W-1:0] sample_count,
	output logic                   dropped
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	logic [DATA_WIDTH-1:0]  x_q;
	logic                   start_q;
	logic [DATA_WIDTH-1:0]  cells_q [CAPACITY];
	logic [CW-1:0]          count_q;
	logic                   drop_q;
	logic [DATA_WIDTH-1:0]  mid_lo_q;
	logic [DATA_WIDTH-1:0]  mid_hi_q;
	logic [DATA_WIDTH:0]    median_q;
	logic [COUNT_OUT_W-1:0] count_out_q;
	logic                   dropped_q;

	logic [CW-1:0]          eff_count;
	logic                   full;
	logic [CAPACITY-1:0]    gt;
	logic [CAPACITY-1:0]    prev_gt;
	logic [DATA_WIDTH-1:0]  below [CAPACITY];
	logic [IW-1:0]          mid_idx;
	logic [IW-1:0]          mid_idx_m1;

	assign eff_count = start_q ? '0 : count_q;
	assign full      = (eff_count == CW'(CAPACITY));

	// A held cell greater than the new sample moves up by one place.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			gt[i] = (CW'(i) < eff_count) && ($signed(cells_q[i]) > $signed(x_q));
		end
		prev_gt[0] = 1'b0;
		below[0]   = x_q;
		for (int i = 1; i < CAPACITY; i++) begin
			prev_gt[i] = gt[i-1];
			below[i]   = cells_q[i-1];
		end
	end

	assign mid_idx    = IW'(count_q >> 1);
	assign mid_idx_m1 = IW'(mid_idx - 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= sample;
			start_q <= start_new;
		end
		if (cmd.insert) begin
			drop_q <= full;
			if (!full) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (CW'(i) <= eff_count) begin
						if (prev_gt[i]) begin
							cells_q[i] <= below[i];
						end else if (gt[i] || (CW'(i) == eff_count)) begin
							cells_q[i] <= x_q;
						end
					end
				end
			end
		end
		if (cmd.select) begin
			mid_hi_q <= cells_q[mid_idx];
			mid_lo_q <= count_q[0] ? cells_q[mid_idx] : cells_q[mid_idx_m1];
		end
		if (cmd.finish) begin
			median_q    <= {mid_lo_q[DATA_WIDTH-1], mid_lo_q}
			             + {mid_hi_q[DATA_WIDTH-1], mid_hi_q};
			count_out_q <= COUNT_OUT_W'(count_q);
			dropped_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= full ? eff_count : CW'(eff_count + 1'b1);
		end
	end

	assign median_x2    = median_q;
	assign sample_count = count_out_q;
	assign dropped      = dropped_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("held count exceeds the store depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert && full |=> (count_q == CW'(CAPACITY)) && drop_q)
		else $error("dropped item did not leave the store full");

	a_low_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> ($signed(cells_q[0]) <= $signed(cells_q[1])))
		else $error("lowest cells out of order");

endmodule

>>> src/running_median_insertion_core.sv
// The result appears on m_axis_tvalid after the controller steps through capture,
// insertion across the cell row, middle selection and result load, which waits while
// an earlier result is not yet taken. A new item is accepted only after that load.
// A waiting result sits in the output register while the next item is already taken.
// Reset clears the controller, the output valid flag and the held count; the store
// is then empty and its cells hold no meaningful data until written.
// ----------------------------------------------------------------------------
// Running median by sorted insertion
// Inserts each signed sample into a sorted store unless it is full, and returns twice the median.
// ----------------------------------------------------------------------------
module running_median_insertion_core
	import rmi_pkg::*;
#(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           s_axis_tvalid,
	output logic                                           s_axis_tready,
	// Fields from bit 0: sample.
	input  logic [((DATA_WIDTH+7)/8)*8-1:0]                s_axis_tdata,
	// Fields from bit 0: start_new.
	input  logic [0:0]                                     s_axis_tuser,
	output logic                                           m_axis_tvalid,
	input  logic                                           m_axis_tready,
	// Fields from bit 0: median_x2, sample_count.
	output logic [((DATA_WIDTH+1+COUNT_OUT_W+7)/8)*8-1:0]  m_axis_tdata,
	// Fields from bit 0: dropped.
	output logic [0:0]                                     m_axis_tuser
);

	localparam int M_W   = ((DATA_WIDTH + 1 + COUNT_OUT_W + 7) / 8) * 8;
	localparam int M_PAD = M_W - (DATA_WIDTH + 1 + COUNT_OUT_W);

	rmi_cmd_t               cmd;
	logic [DATA_WIDTH:0]    median_x2;
	logic [COUNT_OUT_W-1:0] sample_count;
	logic                   dropped;

	rmi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.cmd      (cmd)
	);

	rmi_datapath #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample       (s_axis_tdata[DATA_WIDTH-1:0]),
		.start_new    (s_axis_tuser[0]),
		.median_x2    (median_x2),
		.sample_count (sample_count),
		.dropped      (dropped)
	);

	generate
		if (M_PAD > 0) begin : g_pad
			assign m_axis_tdata = {{M_PAD{1'b0}}, sample_count, median_x2};
		end else begin : g_nopad
			assign m_axis_tdata = {sample_count, median_x2};
		end
	endgenerate

	assign m_axis_tuser = dropped;

endmodule
